### sv/gnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_pkg
// Shared types and constants of the 2D gradient noise sampler.
// ----------------------------------------------------------------------------
package gnd_pkg;

  localparam int GridSizeDef    = 256;
  localparam int CoordFracBits  = 16;   // fraction bits of the sample point
  localparam int GradBits       = 16;   // gradient format Q1.(GradBits-2)
  localparam int DotShift       = GradBits - 2 + 17;

  // 1/sqrt(2) in Q16
  localparam logic signed [17:0] InvSqrt2 = 18'sd46341;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSample = 1'b1;

  // one gradient table entry: x in the low half, y in the high half
  typedef struct packed {
    logic signed [15:0] gy;
    logic signed [15:0] gx;
  } gnd_grad_t;

endpackage

### sv/gnd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gnd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/gnd_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_corner
// Corner contribution: gradient dot offset, scaled by 1/sqrt(2), rounded.
// Three register stages.
// ----------------------------------------------------------------------------
module gnd_corner import gnd_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  gnd_grad_t          grad_i,
  input  logic signed [17:0] dx_i,
  input  logic signed [17:0] dy_i,
  output logic signed [18:0] v_o
);

  logic signed [33:0] px_q, py_q;
  logic signed [34:0] dot;
  logic signed [52:0] m_d, m_q;
  logic signed [52:0] rnd;
  logic signed [18:0] v_q;

  assign dot = 35'(px_q) + 35'(py_q);
  assign m_d = dot * InvSqrt2;
  // round half up is an add then an arithmetic shift
  assign rnd = (m_q + (53'sd1 <<< (DotShift - 1))) >>> DotShift;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= grad_i.gx * dx_i;
      py_q <= grad_i.gy * dy_i;
      m_q  <= m_d;
      v_q  <= rnd[18:0];
    end
  end

  assign v_o = v_q;

endmodule

### sv/gnd_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_fade
// Quintic fade 6t^5 - 15t^4 + 10t^3 in Q16, clamped to 0..1.
// Five register stages, with multiplies in the first, second and fourth.
// ----------------------------------------------------------------------------
module gnd_fade (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] t_i,
  output logic [16:0] f_o
);

  logic [15:0]        t1_q;
  logic [31:0]        sq_q;
  logic [15:0]        t2;
  logic [31:0]        c3_q;
  logic signed [21:0] inner;
  logic signed [38:0] ti_d, ti_q;
  logic [32:0]        c3_rnd;
  logic [32:0]        sq_rnd;
  logic signed [38:0] ti_rnd;
  logic [15:0]        t3_q;
  logic signed [21:0] in2_d, in2_q;
  logic signed [38:0] fr_d, fr_q;
  logic signed [38:0] g;
  logic [16:0]        f_d, f_q;

  assign sq_rnd = (33'(sq_q) + 33'd32768) >> 16;
  assign t2     = sq_rnd[15:0];
  assign inner  = $signed({6'b0, t1_q}) * 22'sd6 - 22'sd983040;
  assign ti_d   = $signed({1'b0, t1_q}) * inner;

  assign c3_rnd = (33'(c3_q) + 33'd32768) >> 16;
  assign ti_rnd = (ti_q + 39'sd32768) >>> 16;
  assign in2_d  = ti_rnd[21:0] + 22'sd655360;

  assign fr_d   = $signed({1'b0, t3_q}) * in2_q;
  assign g      = (fr_q + 39'sd32768) >>> 16;

  always_comb begin
    priority if (g < 39'sd0) begin
      f_d = 17'd0;
    end else if (g > 39'sd65536) begin
      f_d = 17'd65536;
    end else begin
      f_d = g[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q  <= t_i;
      sq_q  <= t_i * t_i;
      c3_q  <= t2 * t1_q;
      ti_q  <= ti_d;
      t3_q  <= c3_rnd[15:0];
      in2_q <= in2_d;
      fr_q  <= fr_d;
      f_q   <= f_d;
    end
  end

  assign f_o = f_q;

endmodule

### sv/gnd_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_lerp
// a + round((b - a) * w / 2^16), w in Q16. Two register stages.
// ----------------------------------------------------------------------------
module gnd_lerp #(
  parameter int W = 19
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic [16:0]         w_i,
  output logic signed [W:0]   r_o
);

  logic signed [W:0]    d;
  logic signed [W+18:0] p_d, p_q, sh;
  logic signed [W-1:0]  a_q;
  logic signed [W:0]    r_d, r_q;

  assign d   = {b_i[W-1], b_i} - {a_i[W-1], a_i};
  assign p_d = d * $signed({1'b0, w_i});
  assign sh  = (p_q + (W+19)'(32768)) >>> 16;
  assign r_d = sh[W:0] + {a_q[W-1], a_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      a_q <= a_i;
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

### sv/gradient_noise_2d_sampler.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; the whole pipeline holds only when a result
// waits at the output. Loads give no result.
// Reset clears the pipeline valid bits; the gradient table keeps its contents
// and holds undefined data until loaded.
// ----------------------------------------------------------------------------
// gradient_noise_2d_sampler
// 2D gradient noise: four parity banks give all corners at once, then
// dot products, fade, and three lerps in a stalling pipeline.
// ----------------------------------------------------------------------------
module gradient_noise_2d_sampler import gnd_pkg::*; #(
  parameter int GRID_SIZE = GridSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               op_i,
  input  logic [15:0]        table_index_i,
  input  logic signed [15:0] grad_x_i,
  input  logic signed [15:0] grad_y_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] noise_value_o
);

  localparam int CellBits  = $clog2(GRID_SIZE);
  localparam int IdxBits   = 2 * CellBits;
  localparam int BankDepth = GRID_SIZE * GRID_SIZE / 4;
  localparam int Depth     = 11;

  logic en, in_xfer;
  logic [Depth-1:0] vld_q;

  assign en      = !vld_q[Depth-1] || !stall_i;
  assign stall_o = !en;
  assign in_xfer = valid_i && en;

  // load address
  logic [IdxBits-1:0]  ld_idx;
  logic [CellBits-1:0] ld_row, ld_col;
  assign ld_idx = IdxBits'(table_index_i);
  assign ld_row = ld_idx[IdxBits-1:CellBits];
  assign ld_col = ld_idx[CellBits-1:0];

  // sample cells, wrapped by masking
  logic [CellBits-1:0] cx0, cx1, cy0, cy1;
  logic [15:0]         tx, ty;
  assign cx0 = coord_x_i[CoordFracBits +: CellBits];
  assign cy0 = coord_y_i[CoordFracBits +: CellBits];
  assign cx1 = cx0 + 1'b1;
  assign cy1 = cy0 + 1'b1;
  assign tx  = coord_x_i[CoordFracBits-1 -: 16];
  assign ty  = coord_y_i[CoordFracBits-1 -: 16];

  // bank b holds entries with row parity b[1] and column parity b[0]
  logic [31:0] rdata [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic RowPar = 1'(b >> 1);
    localparam logic ColPar = 1'(b & 1);
    logic                we;
    logic [CellBits-1:0] rrow, rcol;
    assign we   = in_xfer && (op_i == OpLoad) && (ld_row[0] == RowPar) &&
                  (ld_col[0] == ColPar);
    assign rrow = (cy0[0] == RowPar) ? cy0 : cy1;
    assign rcol = (cx0[0] == ColPar) ? cx0 : cx1;
    gnd_ram #(
      .WIDTH (32),
      .DEPTH (BankDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i ({ld_row[CellBits-1:1], ld_col[CellBits-1:1]}),
      .wdata_i ({grad_y_i, grad_x_i}),
      .re_i    (en),
      .raddr_i ({rrow[CellBits-1:1], rcol[CellBits-1:1]}),
      .rdata_o (rdata[b])
    );
  end

  // stage 1
  logic [15:0] tx_q, ty_q;
  logic        xp_q, yp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= tx;
      ty_q <= ty;
      xp_q <= cx0[0];
      yp_q <= cy0[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_xfer && (op_i == OpSample)};
    end
  end

  gnd_grad_t g00, g10, g01, g11;
  assign g00 = gnd_grad_t'(rdata[{yp_q, xp_q}]);
  assign g10 = gnd_grad_t'(rdata[{yp_q, !xp_q}]);
  assign g01 = gnd_grad_t'(rdata[{!yp_q, xp_q}]);
  assign g11 = gnd_grad_t'(rdata[{!yp_q, !xp_q}]);

  logic signed [17:0] dx0, dx1, dy0, dy1;
  assign dx0 = $signed({2'b0, tx_q});
  assign dy0 = $signed({2'b0, ty_q});
  assign dx1 = dx0 - 18'sd65536;
  assign dy1 = dy0 - 18'sd65536;

  logic signed [18:0] v [4];
  gnd_corner u_c0 (.clk_i, .en_i(en), .grad_i(g01), .dx_i(dx0), .dy_i(dy1), .v_o(v[0]));
  gnd_corner u_c1 (.clk_i, .en_i(en), .grad_i(g11), .dx_i(dx1), .dy_i(dy1), .v_o(v[1]));
  gnd_corner u_c2 (.clk_i, .en_i(en), .grad_i(g00), .dx_i(dx0), .dy_i(dy0), .v_o(v[2]));
  gnd_corner u_c3 (.clk_i, .en_i(en), .grad_i(g10), .dx_i(dx1), .dy_i(dy0), .v_o(v[3]));

  logic [16:0] sx, sy;
  gnd_fade u_fx (.clk_i, .en_i(en), .t_i(tx_q), .f_o(sx));
  gnd_fade u_fy (.clk_i, .en_i(en), .t_i(ty_q), .f_o(sy));

  // corners finish two stages before the fades
  logic signed [18:0] va_q [4];
  logic signed [18:0] vb_q [4];
  logic [16:0]        sya_q, syb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        va_q[i] <= v[i];
        vb_q[i] <= va_q[i];
      end
      sya_q <= sy;
      syb_q <= sya_q;
    end
  end

  logic signed [19:0] top, bot;
  gnd_lerp #(.W(19)) u_lt (
    .clk_i, .en_i(en), .a_i(vb_q[0]), .b_i(vb_q[1]), .w_i(sx), .r_o(top)
  );
  gnd_lerp #(.W(19)) u_lb (
    .clk_i, .en_i(en), .a_i(vb_q[2]), .b_i(vb_q[3]), .w_i(sx), .r_o(bot)
  );

  logic signed [20:0] r;
  gnd_lerp #(.W(20)) u_ly (
    .clk_i, .en_i(en), .a_i(bot), .b_i(top), .w_i(syb_q), .r_o(r)
  );

  logic signed [15:0] out_d, out_q;
  always_comb begin
    priority if (r > 21'sd32767) begin
      out_d = 16'sh7fff;
    end else if (r < -21'sd32768) begin
      out_d = 16'sh8000;
    end else begin
      out_d = r[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign valid_o       = vld_q[Depth-1];
  assign noise_value_o = out_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o) else $error("input stalled with empty output");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("pipeline moved while stalled");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o && op_i == OpLoad) |=> !vld_q[0])
    else $error("load entered the sample pipeline");

  a_sample_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o && op_i == OpSample) |=> vld_q[0])
    else $error("sample transfer lost");

endmodule

### bench/gradient_noise_2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_checker
// Watches both channels of the noise sampler, keeps a shadow gradient table,
// predicts each sample's noise value and compares results in order.
// ----------------------------------------------------------------------------
module gradient_noise_2d_checker import gnd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               stall_o,
  input  logic               op_i,
  input  logic [15:0]        table_index_i,
  input  logic signed [15:0] grad_x_i,
  input  logic signed [15:0] grad_y_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic               valid_o,
  input  logic               stall_i,
  input  logic signed [15:0] noise_value_o,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam longint OneQ16 = 65536;

  gnd_grad_t          shadow_grads [GridSizeDef*GridSizeDef];
  logic signed [15:0] noise_expected [$];

  initial begin
    errors_o  = 0;
    checked_o = 0;
    pending_o = 0;
  end

  function automatic longint round_shr(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint corner_dot(longint cx, longint cy, longint dx, longint dy);
    int        idx;
    gnd_grad_t g;
    longint    dot;
    idx = int'((cy & (GridSizeDef - 1)) * GridSizeDef + (cx & (GridSizeDef - 1)));
    g   = shadow_grads[idx];
    dot = longint'(g.gx) * dx + longint'(g.gy) * dy;
    return round_shr(dot * longint'(InvSqrt2), DotShift);
  endfunction

  function automatic longint fade_q16(longint t);
    longint t2, t3, inner, inner2, f;
    t2     = round_shr(t * t, 16);
    t3     = round_shr(t2 * t, 16);
    inner  = t * 6 - 15 * OneQ16;
    inner2 = round_shr(t * inner, 16) + 10 * OneQ16;
    f      = round_shr(t3 * inner2, 16);
    if (f < 0) f = 0;
    if (f > OneQ16) f = OneQ16;
    return f;
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint w);
    return a + round_shr((b - a) * w, 16);
  endfunction

  function automatic logic signed [15:0] predict_noise(logic signed [31:0] cx,
                                                       logic signed [31:0] cy);
    longint x0, y0, tx, ty, v0, v1, v2, v3, sx, sy, top, bot, r;
    x0  = longint'(cx) >>> CoordFracBits;
    y0  = longint'(cy) >>> CoordFracBits;
    tx  = longint'({48'd0, cx[15:0]});
    ty  = longint'({48'd0, cy[15:0]});
    v0  = corner_dot(x0, y0 + 1, tx, ty - OneQ16);
    v1  = corner_dot(x0 + 1, y0 + 1, tx - OneQ16, ty - OneQ16);
    v2  = corner_dot(x0, y0, tx, ty);
    v3  = corner_dot(x0 + 1, y0, tx - OneQ16, ty);
    sx  = fade_q16(tx);
    sy  = fade_q16(ty);
    top = lerp_q16(v0, v1, sx);
    bot = lerp_q16(v2, v3, sx);
    r   = lerp_q16(bot, top, sy);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        if (op_i == OpLoad)
          shadow_grads[table_index_i] = '{gy: grad_y_i, gx: grad_x_i};
        else
          noise_expected.push_back(predict_noise(coord_x_i, coord_y_i));
      end
      if (valid_o && !stall_i) begin
        if (noise_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result noise_value=%0d", noise_value_o));
        end else begin
          logic signed [15:0] want;
          want = noise_expected.pop_front();
          checked_o++;
          if (noise_value_o !== want)
            report_mismatch($sformatf("noise_value got %0d want %0d", noise_value_o, want));
        end
      end
      pending_o = noise_expected.size();
    end
  end

endmodule

### bench/gradient_noise_2d_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_sampler_tb
// Loads gradients and samples noise points, directed extremes first and then
// random traffic, under four idle/stall phases; a checker scores the results.
// ----------------------------------------------------------------------------
module gradient_noise_2d_sampler_tb;
  import gnd_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int ItemsPerPhase = 250;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic               op_i = OpLoad;
  logic [15:0]        table_index_i = '0;
  logic signed [15:0] grad_x_i = '0;
  logic signed [15:0] grad_y_i = '0;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic signed [15:0] noise_value_o;

  int errors, pending, checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int loads_sent = 0;
  int items_sent = 0;
  bit loaded [GridSizeDef*GridSizeDef];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gradient_noise_2d_sampler dut (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_i), .stall_o(stall_o), .op_i(op_i),
    .table_index_i(table_index_i), .grad_x_i(grad_x_i), .grad_y_i(grad_y_i),
    .coord_x_i(coord_x_i), .coord_y_i(coord_y_i), .valid_o(valid_o),
    .stall_i(stall_i), .noise_value_o(noise_value_o)
  );

  gradient_noise_2d_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_i), .stall_o(stall_o), .op_i(op_i),
    .table_index_i(table_index_i), .grad_x_i(grad_x_i), .grad_y_i(grad_y_i),
    .coord_x_i(coord_x_i), .coord_y_i(coord_y_i), .valid_o(valid_o),
    .stall_i(stall_i), .noise_value_o(noise_value_o),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  always @(posedge clk) begin
    if (rst_n) stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called at a rising edge; returns at the rising edge of the transfer
  task automatic send_item(logic op, logic [15:0] idx, logic signed [15:0] gx,
                           logic signed [15:0] gy, logic signed [31:0] cx,
                           logic signed [31:0] cy);
    if ($urandom_range(0, 99) < idle_pct) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    valid_i       <= 1'b1;
    op_i          <= op;
    table_index_i <= idx;
    grad_x_i      <= gx;
    grad_y_i      <= gy;
    coord_x_i     <= cx;
    coord_y_i     <= cy;
    forever begin
      @(negedge clk);
      if (!stall_o) break;
      @(posedge clk);
    end
    @(posedge clk);
    items_sent++;
  endtask

  function automatic logic signed [15:0] rand_grad();
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic load_grad(logic [15:0] idx, logic signed [15:0] gx, logic signed [15:0] gy);
    send_item(OpLoad, idx, gx, gy, $urandom(), $urandom());
    loaded[idx] = 1'b1;
    loads_sent++;
  endtask

  // makes sure all four corners have been loaded before the sample goes out
  task automatic sample_point(logic signed [31:0] cx, logic signed [31:0] cy);
    logic [7:0]  xc, yc;
    logic [15:0] idx;
    xc = cx[23:16];
    yc = cy[23:16];
    for (int k = 0; k < 4; k++) begin
      idx = {yc + 8'(k / 2), xc + 8'(k % 2)};
      if (!loaded[idx]) load_grad(idx, rand_grad(), rand_grad());
    end
    send_item(OpSample, 16'($urandom()), 16'($urandom()), 16'($urandom()), cx, cy);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 20 * 65536) - 10 * 65536;
      2: return {16'($urandom_range(0, 7)), 16'($urandom())};
      default: return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom())};
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: gradient extremes, out-of-unit gradients, coordinate extremes
    load_grad(16'h0000, 16'sd16384, -16'sd16384);
    load_grad(16'h0001, -16'sd16384, 16'sd16384);
    load_grad(16'h0100, 16'sh7FFF, 16'sh7FFF);
    load_grad(16'h0101, -16'sh8000, -16'sh8000);
    load_grad(16'hFFFF, 16'sd0, 16'sd16384);
    load_grad(16'hFF00, 16'sd16384, 16'sd0);
    load_grad(16'h00FF, -16'sd16384, 16'sd0);
    sample_point(32'sh0000_0000, 32'sh0000_0000);
    sample_point(32'sh0000_8000, 32'sh0000_8000);
    sample_point(32'sh0000_FFFF, 32'sh0000_FFFF);
    sample_point(32'sh0000_C000, 32'sh0000_4000);
    sample_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    sample_point(32'sh8000_0000, 32'sh8000_0000);
    sample_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    sample_point(32'shFFFF_FFFF, 32'shFFFF_FFFF);
    sample_point(32'shFFFF_0000, 32'sh0000_0001);
    sample_point(32'sh00FF_8000, 32'sh00FF_8000);
    sample_point(32'shFFFF_8000, 32'sh0000_8000);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 31 : 0;
      stall_pct = (ph == 2) ? 50 : (ph == 3) ? 31 : 0;
      while (items_sent < ItemsPerPhase * (ph + 1)) begin
        if ($urandom_range(0, 99) < 25) load_grad(16'($urandom()), rand_grad(), rand_grad());
        else sample_point(rand_coord(), rand_coord());
      end
    end

    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk);
    stall_pct = 0;
    repeat (30) @(posedge clk);

    $display("covered %0d items: %0d gradient loads and %0d checked noise samples",
             items_sent, loads_sent, checked);
    $display("phases: free run, sender gaps, receiver stalls, both");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
